// ----- hdl/r2h_pkg.sv -----
// Shared constants and types for the RGB to HSV pixel converter.
`timescale 1ns / 1ps

package r2h_pkg;

  localparam int CHAN_W = 8;                  // width of one color channel
  localparam int HUE_W  = 9;                  // hue in degrees, 0..359
  localparam int HUE_QW = 9;                  // hue quotient bits (hue < 512)
  localparam int SAT_QW = 8;                  // saturation quotient bits
  localparam int HUE_NW = 17;                 // hue dividend, at most 360*255
  localparam int SAT_NW = 16;                 // saturation dividend, 255*C
  localparam int DIF_W  = 9;                  // signed channel difference
  localparam int PRD_W  = 19;                 // signed numerator before wrap
  localparam int DIV_STAGES = HUE_QW;         // one quotient bit per stage

  localparam int DEG_RED   = 0;
  localparam int DEG_GREEN = 120;
  localparam int DEG_BLUE  = 240;
  localparam int DEG_WRAP  = 360;
  localparam int DEG_SLOPE = 60;

  // Which channel holds the maximum; ties resolve red, then green.
  typedef enum logic [1:0] {
    SEC_RED,
    SEC_GREEN,
    SEC_BLUE
  } sec_t;

  // State carried through the bit-per-stage divider pipeline.
  typedef struct packed {
    logic [HUE_NW-1:0] hrem;
    logic [HUE_QW-1:0] hq;
    logic [CHAN_W-1:0] hdiv;   // chroma
    logic [SAT_NW-1:0] srem;
    logic [SAT_QW-1:0] sq;
    logic [CHAN_W-1:0] sdiv;   // channel max, also the value output
    logic              nz;     // chroma is nonzero
  } div_st_t;

endpackage

// ----- hdl/r2h_ifs.sv -----
// Valid/ready channel interfaces for RGB requests and HSV results.
`timescale 1ns / 1ps

interface r2h_rgb_if;
  logic                          valid;
  logic                          ready;
  logic [r2h_pkg::CHAN_W-1:0]    red_in;
  logic [r2h_pkg::CHAN_W-1:0]    green_in;
  logic [r2h_pkg::CHAN_W-1:0]    blue_in;

  modport source (output valid, red_in, green_in, blue_in, input ready);
  modport sink   (input valid, red_in, green_in, blue_in, output ready);
endinterface

interface r2h_hsv_if;
  logic                          valid;
  logic                          ready;
  logic [r2h_pkg::HUE_W-1:0]     hue_deg;
  logic [r2h_pkg::CHAN_W-1:0]    sat_scaled;
  logic [r2h_pkg::CHAN_W-1:0]    value_out;

  modport source (output valid, hue_deg, sat_scaled, value_out, input ready);
  modport sink   (input valid, hue_deg, sat_scaled, value_out, output ready);
endinterface

// ----- hdl/rgb_to_hsv_pixel.sv -----
// Pipelined RGB to HSV pixel converter, one pixel per clock while hsv takes results.
//
//  channel | dir | payload                               | handshake
//  --------+-----+---------------------------------------+-------------
//  pix     | in  | red_in, green_in, blue_in (8b each)   | valid/ready
//  hsv     | out | hue_deg (9b), sat_scaled, value_out   | valid/ready
//
// Throughput: one request per clock, sustained while hsv keeps ready high.
// Stages from an accepted request to its result showing on hsv:
//   1 stage finds max/min and the hue sector, 1 stage forms chroma and both
//   dividends, then 9 stages of restoring division (one hue quotient bit each,
//   the 8 saturation bits ride along in the first 8 of them).
// Reset clears only the stage valid bits; data registers are not reset.
// Stalls: each stage holds when it is full and the stage after it cannot
//   take its data, so bubbles close up and pix.ready stays high while any
//   stage ahead has room, even with a finished result waiting on hsv.
`timescale 1ns / 1ps

module rgb_to_hsv_pixel (
  input  logic            clk,
  input  logic            rst,
  r2h_rgb_if.sink         pix,
  r2h_hsv_if.source       hsv
);

  localparam int D = r2h_pkg::DIV_STAGES;

  // ---------------------------------------------------------------------
  // Stage A: channel max/min and hue sector
  // ---------------------------------------------------------------------
  logic                                   a_v;
  r2h_pkg::sec_t                          a_sec;
  logic        [r2h_pkg::CHAN_W-1:0]      a_mx;
  logic        [r2h_pkg::CHAN_W-1:0]      a_mn;
  logic signed [r2h_pkg::DIF_W-1:0]       a_dif;

  r2h_pkg::sec_t                          a_sec_next;
  logic        [r2h_pkg::CHAN_W-1:0]      a_mx_next;
  logic        [r2h_pkg::CHAN_W-1:0]      a_mn_next;
  logic signed [r2h_pkg::DIF_W-1:0]       a_dif_next;
  logic                                   a_en;

  // Stage valid bits, data and advance enables through the divider.
  logic                 v  [0:D];
  r2h_pkg::div_st_t     st [0:D];
  logic                 en [0:D];

  always_comb begin
    logic [r2h_pkg::CHAN_W-1:0] r, g, b;
    r = pix.red_in;
    g = pix.green_in;
    b = pix.blue_in;
    // ties go to red, then green
    if (r >= g && r >= b) begin
      a_sec_next = r2h_pkg::SEC_RED;
      a_mx_next  = r;
      a_dif_next = $signed({1'b0, g}) - $signed({1'b0, b});
    end else if (g >= b) begin
      a_sec_next = r2h_pkg::SEC_GREEN;
      a_mx_next  = g;
      a_dif_next = $signed({1'b0, b}) - $signed({1'b0, r});
    end else begin
      a_sec_next = r2h_pkg::SEC_BLUE;
      a_mx_next  = b;
      a_dif_next = $signed({1'b0, r}) - $signed({1'b0, g});
    end
    a_mn_next = r;
    if (g < a_mn_next) a_mn_next = g;
    if (b < a_mn_next) a_mn_next = b;
  end

  assign a_en      = !a_v || en[0];
  assign pix.ready = a_en;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_v <= 1'b0;
    end else if (a_en) begin
      a_v <= pix.valid;
    end
    if (a_en) begin
      a_sec <= a_sec_next;
      a_mx  <= a_mx_next;
      a_mn  <= a_mn_next;
      a_dif <= a_dif_next;
    end
  end

  // ---------------------------------------------------------------------
  // Stage B: chroma, hue dividend and saturation dividend
  // ---------------------------------------------------------------------
  r2h_pkg::div_st_t b_next;

  always_comb begin
    logic        [r2h_pkg::CHAN_W-1:0] c;
    logic        [r2h_pkg::PRD_W-1:0]  base;
    logic signed [r2h_pkg::PRD_W-1:0]  slope;
    logic signed [r2h_pkg::PRD_W-1:0]  hnum;
    c     = a_mx - a_mn;
    slope = r2h_pkg::PRD_W'(a_dif) * r2h_pkg::PRD_W'(r2h_pkg::DEG_SLOPE);
    case (a_sec)
      r2h_pkg::SEC_RED: begin
        // negative red sector wraps by a full turn
        base = a_dif[r2h_pkg::DIF_W-1]
             ? r2h_pkg::PRD_W'(c) * r2h_pkg::PRD_W'(r2h_pkg::DEG_WRAP)
             : r2h_pkg::PRD_W'(r2h_pkg::DEG_RED);
      end
      r2h_pkg::SEC_GREEN: base = r2h_pkg::PRD_W'(c) * r2h_pkg::PRD_W'(r2h_pkg::DEG_GREEN);
      r2h_pkg::SEC_BLUE:  base = r2h_pkg::PRD_W'(c) * r2h_pkg::PRD_W'(r2h_pkg::DEG_BLUE);
      default:            base = '0;
    endcase
    hnum = $signed(base) + slope;

    b_next.hrem = hnum[r2h_pkg::HUE_NW-1:0];
    b_next.hq   = '0;
    b_next.hdiv = c;
    b_next.srem = {c, {r2h_pkg::CHAN_W{1'b0}}} - r2h_pkg::SAT_NW'(c);  // 255*C
    b_next.sq   = '0;
    b_next.sdiv = a_mx;
    b_next.nz   = (c != '0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v[0] <= 1'b0;
    end else if (en[0]) begin
      v[0] <= a_v;
    end
    if (en[0]) begin
      st[0] <= b_next;
    end
  end

  // ---------------------------------------------------------------------
  // Divider: a restoring step per stage on hue; first 8 also on the sat quotient
  // ---------------------------------------------------------------------
  assign en[D] = !v[D] || hsv.ready;

  genvar k;
  generate
    for (k = 0; k < D; k++) begin : g_div
      localparam int HB = r2h_pkg::HUE_QW - 1 - k;
      r2h_pkg::div_st_t step;
      logic [r2h_pkg::HUE_NW-1:0] hsh;

      assign en[k] = !v[k] || en[k+1];
      assign hsh   = r2h_pkg::HUE_NW'(st[k].hdiv) << HB;

      if (k < r2h_pkg::SAT_QW) begin : g_sat
        localparam int SB = r2h_pkg::SAT_QW - 1 - k;
        logic [r2h_pkg::SAT_NW-1:0] ssh;
        assign ssh = r2h_pkg::SAT_NW'(st[k].sdiv) << SB;

        always_comb begin
          step = st[k];
          if (st[k].hrem >= hsh) begin
            step.hrem   = st[k].hrem - hsh;
            step.hq[HB] = 1'b1;
          end
          if (st[k].srem >= ssh) begin
            step.srem   = st[k].srem - ssh;
            step.sq[SB] = 1'b1;
          end
        end
      end else begin : g_hue_only
        always_comb begin
          step = st[k];
          if (st[k].hrem >= hsh) begin
            step.hrem   = st[k].hrem - hsh;
            step.hq[HB] = 1'b1;
          end
        end
      end

      always_ff @(posedge clk) begin
        if (rst) begin
          v[k+1] <= 1'b0;
        end else if (en[k+1]) begin
          v[k+1] <= v[k];
        end
        if (en[k+1]) begin
          st[k+1] <= step;
        end
      end
    end
  endgenerate

  // ---------------------------------------------------------------------
  // Result: gray pixels (zero chroma) report zero hue and saturation
  // ---------------------------------------------------------------------
  assign hsv.valid      = v[D];
  assign hsv.hue_deg    = st[D].nz ? st[D].hq : '0;
  assign hsv.sat_scaled = st[D].nz ? st[D].sq : '0;
  assign hsv.value_out  = st[D].sdiv;

  // ---------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------
  a_hue_range: assert property (@(posedge clk) disable iff (rst)
    hsv.valid |-> hsv.hue_deg < r2h_pkg::HUE_W'(r2h_pkg::DEG_WRAP))
    else $error("hue out of range");

  a_black: assert property (@(posedge clk) disable iff (rst)
    hsv.valid && hsv.value_out == '0 |-> hsv.hue_deg == '0 && hsv.sat_scaled == '0)
    else $error("black pixel with nonzero hue or saturation");

  a_chroma_le_max: assert property (@(posedge clk) disable iff (rst)
    v[0] |-> st[0].hdiv <= st[0].sdiv)
    else $error("chroma exceeds channel max");

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    v[D] && !hsv.ready |=> v[D] && $stable(st[D].hq) && $stable(st[D].sq))
    else $error("stalled result changed in last stage");

endmodule

// ----- dv/tb_rgb_to_hsv_pixel.sv -----
// Self-checking testbench for the RGB to HSV pixel converter.
`timescale 1ns / 1ps

module tb_rgb_to_hsv_pixel;

  localparam int WATCHDOG_LIMIT = 5000;  // cycles with no request moving on either side
  localparam int IDLE_MAX       = 19;    // widest random gap on either side
  localparam int DRAIN_TAIL     = 30;    // pipeline is 11 deep, plus margin
  localparam int LONG_HOLD      = 400;   // sink hold-off used to back up the pipeline

  typedef struct packed {
    logic [r2h_pkg::HUE_W-1:0]  hue;
    logic [r2h_pkg::CHAN_W-1:0] sat;
    logic [r2h_pkg::CHAN_W-1:0] val;
  } hsv_t;

  logic clk;
  logic rst;

  r2h_rgb_if pix_bus ();
  r2h_hsv_if hsv_bus ();

  rgb_to_hsv_pixel dut (
    .clk (clk),
    .rst (rst),
    .pix (pix_bus),
    .hsv (hsv_bus)
  );

  hsv_t hsv_expected_q[$];
  int   mismatch_count = 0;
  int   src_gap_max    = 0;
  int   sink_gap_max   = 0;
  int   sink_hold      = 0;   // one-shot long stall, picked up by the sink process
  int   idle_cycles    = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Exact integer HSV: max channel picks the sector, red wins ties, then green.
  // The red sector wraps negatives by adding 360*C before the floor divide.
  function automatic hsv_t predict_hsv(input logic [r2h_pkg::CHAN_W-1:0] r, g, b);
    int   mx, mn, chroma, num;
    hsv_t res;
    mx = r;
    if (g > mx) mx = g;
    if (b > mx) mx = b;
    mn = r;
    if (g < mn) mn = g;
    if (b < mn) mn = b;
    chroma = mx - mn;
    res = '0;
    res.val = mx[r2h_pkg::CHAN_W-1:0];
    if (chroma > 0) begin
      if (mx == r) begin
        num = r2h_pkg::DEG_SLOPE * (int'(g) - int'(b));
        if (num < 0) num += r2h_pkg::DEG_WRAP * chroma;
      end else if (mx == g) begin
        num = r2h_pkg::DEG_GREEN * chroma + r2h_pkg::DEG_SLOPE * (int'(b) - int'(r));
      end else begin
        num = r2h_pkg::DEG_BLUE * chroma + r2h_pkg::DEG_SLOPE * (int'(r) - int'(g));
      end
      res.hue = r2h_pkg::HUE_W'(num / chroma);
      res.sat = r2h_pkg::CHAN_W'((255 * chroma) / mx);
    end
    return res;
  endfunction

  // Half uniform pixels, the other half grays, two-way ties and near-black.
  function automatic void rand_pixel(output logic [r2h_pkg::CHAN_W-1:0] r, g, b);
    int kind;
    kind = $urandom_range(0, 9);
    r = r2h_pkg::CHAN_W'($urandom);
    g = r2h_pkg::CHAN_W'($urandom);
    b = r2h_pkg::CHAN_W'($urandom);
    case (kind)
      0: begin
        g = r;
        b = r;
      end
      1: g = r;
      2: b = g;
      3: b = r;
      4: begin
        r = r2h_pkg::CHAN_W'($urandom_range(0, 3));
        g = r2h_pkg::CHAN_W'($urandom_range(0, 3));
        b = r2h_pkg::CHAN_W'($urandom_range(0, 3));
      end
      default: ;
    endcase
  endfunction

  // Offer one request; returns at the edge where it is taken. Valid is only
  // dropped when a gap follows, so back-to-back requests keep it high.
  task automatic send_pixel(input logic [r2h_pkg::CHAN_W-1:0] r, g, b);
    int gap;
    gap = $urandom_range(0, src_gap_max);
    if (gap > 0) begin
      pix_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    pix_bus.valid    <= 1'b1;
    pix_bus.red_in   <= r;
    pix_bus.green_in <= g;
    pix_bus.blue_in  <= b;
    do @(posedge clk); while (!pix_bus.ready);
    hsv_expected_q.push_back(predict_hsv(r, g, b));
  endtask

  task automatic send_random(input int count);
    logic [r2h_pkg::CHAN_W-1:0] r, g, b;
    repeat (count) begin
      rand_pixel(r, g, b);
      send_pixel(r, g, b);
    end
  endtask

  // Stop offering and wait for every outstanding result.
  task automatic drain;
    pix_bus.valid <= 1'b0;
    while (hsv_expected_q.size() != 0) @(posedge clk);
  endtask

  task automatic test_corner_pixels;
    src_gap_max  = 0;
    sink_gap_max = 0;
    send_pixel(8'd0,   8'd0,   8'd0);     // black
    send_pixel(8'd255, 8'd255, 8'd255);   // white
    send_pixel(8'd128, 8'd128, 8'd128);   // mid gray
    send_pixel(8'd255, 8'd0,   8'd0);     // primaries
    send_pixel(8'd0,   8'd255, 8'd0);
    send_pixel(8'd0,   8'd0,   8'd255);
    send_pixel(8'd255, 8'd255, 8'd0);     // red/green tie goes to red
    send_pixel(8'd0,   8'd255, 8'd255);   // green/blue tie goes to green
    send_pixel(8'd255, 8'd0,   8'd255);   // red/blue tie, wrapped red sector
    send_pixel(8'd200, 8'd10,  8'd11);    // wrap lands just under 360
    send_pixel(8'd255, 8'd0,   8'd1);
    send_pixel(8'd255, 8'd254, 8'd0);     // just under the green boundary
    send_pixel(8'd1,   8'd0,   8'd0);     // chroma one, full saturation
    send_pixel(8'd0,   8'd1,   8'd0);
    send_pixel(8'd0,   8'd0,   8'd1);
    send_pixel(8'd1,   8'd2,   8'd0);
    send_pixel(8'd254, 8'd255, 8'd253);   // tiny chroma at the top
    send_pixel(8'd3,   8'd200, 8'd255);
    send_pixel(8'd170, 8'd85,  8'd15);
    send_pixel(8'd85,  8'd170, 8'd240);
    drain();
  endtask

  task automatic test_random_handshake;
    src_gap_max  = IDLE_MAX;
    sink_gap_max = IDLE_MAX;
    send_random(500);
    drain();
  endtask

  // No idling anywhere: one request per clock through the whole pipeline.
  task automatic test_full_rate;
    src_gap_max  = 0;
    sink_gap_max = 0;
    send_random(400);
    drain();
  endtask

  // Sink stops for a long stretch while the source keeps offering, so the
  // pipeline fills and must hold off the input.
  task automatic test_output_backpressure;
    src_gap_max  = 0;
    sink_gap_max = 0;
    sink_hold    = LONG_HOLD;
    send_random(100);
    drain();
  endtask

  // Bursts with idling switched on or off at random on each side.
  task automatic test_random_mixed;
    repeat (10) begin
      src_gap_max  = ($urandom_range(0, 1) != 0) ? IDLE_MAX : 0;
      sink_gap_max = ($urandom_range(0, 1) != 0) ? IDLE_MAX : 0;
      send_random(50);
    end
    drain();
  endtask

  // Result sink: a random stall per result, or the one-shot long hold.
  initial begin
    int stall;
    hsv_bus.ready <= 1'b0;
    do @(posedge clk); while (rst !== 1'b0);
    forever begin
      if (sink_hold > 0) begin
        stall     = sink_hold;
        sink_hold = 0;
      end else begin
        stall = $urandom_range(0, sink_gap_max);
      end
      if (stall > 0) begin
        hsv_bus.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      hsv_bus.ready <= 1'b1;
      do @(posedge clk); while (!hsv_bus.valid);
    end
  end

  // Result checker: every accepted result against the oldest prediction.
  always @(posedge clk) begin
    hsv_t want;
    if (!rst && hsv_bus.valid && hsv_bus.ready) begin
      if (hsv_expected_q.size() == 0) begin
        mismatch_count++;
        $display("%0t: unexpected result hue=%0d sat=%0d val=%0d", $time,
                 hsv_bus.hue_deg, hsv_bus.sat_scaled, hsv_bus.value_out);
      end else begin
        want = hsv_expected_q.pop_front();
        if (hsv_bus.hue_deg !== want.hue) begin
          mismatch_count++;
          $display("%0t: hue_deg expected %0d actual %0d", $time, want.hue,
                   hsv_bus.hue_deg);
        end
        if (hsv_bus.sat_scaled !== want.sat) begin
          mismatch_count++;
          $display("%0t: sat_scaled expected %0d actual %0d", $time, want.sat,
                   hsv_bus.sat_scaled);
        end
        if (hsv_bus.value_out !== want.val) begin
          mismatch_count++;
          $display("%0t: value_out expected %0d actual %0d", $time, want.val,
                   hsv_bus.value_out);
        end
      end
    end
  end

  // Watchdog: too long with no request moving on either channel.
  always @(posedge clk) begin
    if (rst || (pix_bus.valid && pix_bus.ready) || (hsv_bus.valid && hsv_bus.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t: timeout, nothing accepted for %0d cycles", $time, idle_cycles);
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  initial begin
    rst              <= 1'b1;
    pix_bus.valid    <= 1'b0;
    pix_bus.red_in   <= '0;
    pix_bus.green_in <= '0;
    pix_bus.blue_in  <= '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_corner_pixels();
    test_random_handshake();
    test_full_rate();
    test_output_backpressure();
    test_random_mixed();

    // Tail: catch any stray result after the last expected one.
    repeat (DRAIN_TAIL) @(posedge clk);
    if (mismatch_count == 0 && hsv_expected_q.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
